// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the resource name hash RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define RNH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define RNH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rnh_pkg.sv =====
// Package with constants, codes and control structs of the resource name hash.
`timescale 1ns / 1ps
package rnh_pkg;

  localparam int unsigned MAX_WORDS   = 64;
  localparam int unsigned WORD_CNT_W  = $clog2(MAX_WORDS + 1);

  localparam logic [31:0] ROTOR_INIT  = 32'hF4FA8928;
  localparam logic [31:0] LANE_A_INIT = 32'h37A8470E;
  localparam logic [31:0] LANE_B_INIT = 32'h7758B42B;
  localparam logic [31:0] TAIL_WORD0  = 32'h9BE74448;
  localparam logic [31:0] TAIL_WORD1  = 32'h66F42C48;
  localparam logic [31:0] SALT        = 32'h267B0B11;
  localparam logic [31:0] SET_A       = 32'h02040801;
  localparam logic [31:0] KEEP_A      = 32'hBFEF7FDF;
  localparam logic [31:0] SET_B       = 32'h00804021;
  localparam logic [31:0] KEEP_B      = 32'h7DFEFBFF;

  localparam logic KIND_WORD = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Which word a mixing round uses.
  typedef enum logic [1:0] {
    RND_WORD  = 2'd0,
    RND_TAIL0 = 2'd1,
    RND_TAIL1 = 2'd2
  } round_t;

  typedef struct packed {
    logic   load_word;
    logic   count;
    logic   close;
    logic   step_a;
    logic   step_b;
    logic   step_fold;
    logic   emit;
    round_t rnd;
  } cmd_t;

  typedef struct packed {
    logic closed;
    logic full;
    logic word_zero;
  } status_t;

endpackage

// ===== rtl/rnh_intf.sv =====
// Request and result channel interfaces of the resource name hash.
`timescale 1ns / 1ps
interface rnh_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] word;

  modport source (output valid, output kind, output word, input ready);
  modport sink (input valid, input kind, input word, output ready);
endinterface

interface rnh_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash;

  modport source (output valid, output hash, input ready);
  modport sink (input valid, input hash, output ready);
endinterface

// ===== rtl/resource_name_hash.sv =====
// Top level of the resource name hash: controller, datapath and channel ports.
//
//   channel   direction  payload           handshake
//   in_req    sink       kind[0], word[31:0]  valid / ready
//   out_res   source     hash[31:0]        valid / ready
//
// A word request is accepted and then runs three round steps
// (multiply lane A, fold A and multiply lane B, fold B) on one shared 32x32 multiplier.
// An end request runs two tail rounds of three steps and one emit step.
// A zero word, a word after the name closed, or a word past the limit is taken without a round.
// The hash sits in an output register; a stalled result holds only the next end request.
// Reset is synchronous and active low and restores the initial hash state.
`timescale 1ns / 1ps
module resource_name_hash (
  input  logic        clk,
  input  logic        rst_n,
  rnh_req_if.sink     in_req,
  rnh_res_if.source   out_res
);

  rnh_pkg::cmd_t    cmd;
  rnh_pkg::status_t status;

  rnh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_kind   (in_req.kind),
    .in_ready  (in_req.ready),
    .out_ready (out_res.ready),
    .out_valid (out_res.valid),
    .status    (status),
    .cmd       (cmd)
  );

  rnh_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_word (in_req.word),
    .cmd     (cmd),
    .status  (status),
    .hash    (out_res.hash)
  );

endmodule

// ===== rtl/rnh_ctrl.sv =====
// Controller state machine of the resource name hash.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rnh_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_kind,
  output logic            in_ready,
  input  logic            out_ready,
  output logic            out_valid,
  input  rnh_pkg::status_t status,
  output rnh_pkg::cmd_t   cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_MUL_A  = 5'b00010,
    ST_MUL_B  = 5'b00100,
    ST_FOLD_B = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  state_t          state_r, state_nxt;
  rnh_pkg::round_t rnd_r, rnd_nxt;
  logic            out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    cmd.rnd       = rnd_r;
    state_nxt     = state_r;
    rnd_nxt       = rnd_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_kind == rnh_pkg::KIND_END) begin
            rnd_nxt   = rnh_pkg::RND_TAIL0;
            state_nxt = ST_MUL_A;
          end else if (!(status.closed || status.full)) begin
            if (status.word_zero) begin
              cmd.close = 1'b1;
            end else begin
              cmd.load_word = 1'b1;
              cmd.count     = 1'b1;
              rnd_nxt       = rnh_pkg::RND_WORD;
              state_nxt     = ST_MUL_A;
            end
          end
        end
      end
      ST_MUL_A: begin
        cmd.step_a = 1'b1;
        state_nxt  = ST_MUL_B;
      end
      ST_MUL_B: begin
        cmd.step_b = 1'b1;
        state_nxt  = ST_FOLD_B;
      end
      ST_FOLD_B: begin
        cmd.step_fold = 1'b1;
        unique case (rnd_r)
          rnh_pkg::RND_TAIL0: begin
            rnd_nxt   = rnh_pkg::RND_TAIL1;
            state_nxt = ST_MUL_A;
          end
          rnh_pkg::RND_TAIL1: state_nxt = ST_EMIT;
          default:            state_nxt = ST_IDLE;
        endcase
      end
      ST_EMIT: begin
        // The hash waits here until the output register is free.
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rnd_r       <= rnh_pkg::RND_WORD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `RNH_ASSERT_NEXT(a_round_order, state_r == ST_MUL_A, state_r == ST_MUL_B, "round out of order")
  `RNH_ASSERT_NEXT(a_tail_emit, (state_r == ST_FOLD_B) && (rnd_r == rnh_pkg::RND_TAIL1), state_r == ST_EMIT, "last tail round did not lead to emit")
  `RNH_ASSERT_NEXT(a_emit_valid, cmd.emit, out_valid_r, "emitted hash not presented")

endmodule

// ===== rtl/rnh_dp.sv =====
// Datapath of the resource name hash: state registers, shared multiplier and folds.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rnh_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [31:0]      in_word,
  input  rnh_pkg::cmd_t    cmd,
  output rnh_pkg::status_t status,
  output logic [31:0]      hash
);

  logic [31:0] rotor_r, lane_a_r, lane_b_r;
  logic [rnh_pkg::WORD_CNT_W-1:0] words_r;
  logic        closed_r;
  logic [31:0] word_r, c_r, mb_r, hash_r;
  logic [63:0] prod_r;

  logic [31:0] rot_w, b_w, w_sel, a_w, c_w, ma_w, mb_w, mul_x, mul_y;
  logic [63:0] prod_w;

  function automatic logic [31:0] fold_a(input logic [63:0] p);
    logic [32:0] t;
    t = {1'b0, p[31:0]} + {1'b0, p[63:32]} + {32'd0, (p[63:32] != 32'd0)};
    return t[31:0] + {31'd0, t[32]};
  endfunction

  function automatic logic [31:0] fold_b(input logic [63:0] p);
    logic [32:0] t;
    t = {1'b0, p[31:0]} + {1'b0, p[62:32], 1'b0} + {32'd0, p[63]};
    return t[31:0] + (t[32] ? 32'd2 : 32'd0);
  endfunction

  assign status.closed    = closed_r;
  assign status.full      = (words_r >= rnh_pkg::WORD_CNT_W'(rnh_pkg::MAX_WORDS));
  assign status.word_zero = (in_word == 32'd0);
  assign hash             = hash_r;

  always_comb begin
    rot_w = {rotor_r[30:0], rotor_r[31]};
    b_w   = rot_w ^ rnh_pkg::SALT;
    unique case (cmd.rnd)
      rnh_pkg::RND_TAIL0: w_sel = rnh_pkg::TAIL_WORD0;
      rnh_pkg::RND_TAIL1: w_sel = rnh_pkg::TAIL_WORD1;
      default:            w_sel = word_r;
    endcase
    a_w   = lane_a_r ^ w_sel;
    c_w   = lane_b_r ^ w_sel;
    ma_w  = ((b_w + c_w) | rnh_pkg::SET_A) & rnh_pkg::KEEP_A;
    mb_w  = ((b_w + a_w) | rnh_pkg::SET_B) & rnh_pkg::KEEP_B;
    // One multiplier serves lane A in the first step and lane B in the second.
    mul_x = cmd.step_a ? a_w : c_r;
    mul_y = cmd.step_a ? ma_w : mb_r;
  end

  assign prod_w = {32'd0, mul_x} * {32'd0, mul_y};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rotor_r  <= rnh_pkg::ROTOR_INIT;
      lane_a_r <= rnh_pkg::LANE_A_INIT;
      lane_b_r <= rnh_pkg::LANE_B_INIT;
      words_r  <= '0;
      closed_r <= 1'b0;
    end else if (cmd.emit) begin
      rotor_r  <= rnh_pkg::ROTOR_INIT;
      lane_a_r <= rnh_pkg::LANE_A_INIT;
      lane_b_r <= rnh_pkg::LANE_B_INIT;
      words_r  <= '0;
      closed_r <= 1'b0;
    end else begin
      if (cmd.close) begin
        closed_r <= 1'b1;
      end
      if (cmd.count) begin
        words_r <= words_r + rnh_pkg::WORD_CNT_W'(1);
      end
      if (cmd.step_a) begin
        rotor_r <= rot_w;
      end
      if (cmd.step_b) begin
        lane_a_r <= fold_a(prod_r);
      end
      if (cmd.step_fold) begin
        lane_b_r <= fold_b(prod_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_word) begin
      word_r <= in_word;
    end
    if (cmd.step_a) begin
      c_r  <= c_w;
      mb_r <= mb_w;
    end
    if (cmd.step_a || cmd.step_b) begin
      prod_r <= prod_w;
    end
    if (cmd.emit) begin
      hash_r <= lane_a_r ^ lane_b_r;
    end
  end

  `RNH_ASSERT_NEXT(a_emit_restores, cmd.emit,
    (lane_a_r == rnh_pkg::LANE_A_INIT) && (words_r == '0) && !closed_r,
    "state not restored after hash")
  `RNH_ASSERT_NEXT(a_count_step, cmd.count && !cmd.emit,
    words_r == $past(words_r) + rnh_pkg::WORD_CNT_W'(1),
    "word count did not advance")
  `RNH_ASSERT_NOW(a_count_bound, 1'b1,
    words_r <= rnh_pkg::WORD_CNT_W'(rnh_pkg::MAX_WORDS),
    "word count beyond limit")

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the resource name hash: directed table, random names, predictor.
`timescale 1ns / 1ps
module tb_top;

  typedef struct packed {
    logic        kind;
    logic [31:0] word;
  } name_req_t;

  // Directed requests. Hash values need the full mixing rounds, so every row
  // is checked against the predictor.
  localparam int DIR_ROWS = 20;
  localparam name_req_t DIR_TAB [DIR_ROWS] = '{
    '{rnh_pkg::KIND_END,  32'h00000000},  // empty name right after reset
    '{rnh_pkg::KIND_WORD, 32'hFFFFFFFF},
    '{rnh_pkg::KIND_END,  32'hFFFFFFFF},  // word field of an end request is don't-care
    '{rnh_pkg::KIND_WORD, 32'h00000001},
    '{rnh_pkg::KIND_WORD, 32'h80000000},
    '{rnh_pkg::KIND_END,  32'h00000000},
    '{rnh_pkg::KIND_WORD, 32'h00FF0000},  // inner zero bytes are mixed in as given
    '{rnh_pkg::KIND_WORD, 32'h000000FF},
    '{rnh_pkg::KIND_WORD, 32'hFF000000},
    '{rnh_pkg::KIND_END,  32'h12345678},
    '{rnh_pkg::KIND_WORD, 32'h61626364},
    '{rnh_pkg::KIND_WORD, 32'h00000000},  // closes the name
    '{rnh_pkg::KIND_WORD, 32'h65666768},  // ignored after close
    '{rnh_pkg::KIND_WORD, 32'hFFFFFFFF},  // ignored after close
    '{rnh_pkg::KIND_END,  32'hAAAAAAAA},
    '{rnh_pkg::KIND_WORD, 32'h00000000},  // zero word as the very first word
    '{rnh_pkg::KIND_END,  32'h55555555},
    '{rnh_pkg::KIND_WORD, 32'h7FFFFFFF},
    '{rnh_pkg::KIND_WORD, 32'hFFFFFFFE},
    '{rnh_pkg::KIND_END,  32'hFFFFFFFF}
  };

  logic clk = 1'b0;
  logic rst_n;

  rnh_req_if req_if ();
  rnh_res_if res_if ();

  resource_name_hash dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if.sink),
    .out_res (res_if.source)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state.
  logic [31:0] hp_rotor;
  logic [31:0] hp_lane_a;
  logic [31:0] hp_lane_b;
  int unsigned hp_words;
  bit          hp_closed;

  logic [31:0] hash_q [$];
  int          err_count = 0;
  bit          src_calm = 1'b0;
  bit          sink_calm = 1'b0;
  int          sink_hold = 0;

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("MISMATCH %s: want %08h, got %08h at %0t", what, want, got, $realtime);
    err_count++;
  endtask

  function void hash_state_reset();
    hp_rotor  = rnh_pkg::ROTOR_INIT;
    hp_lane_a = rnh_pkg::LANE_A_INIT;
    hp_lane_b = rnh_pkg::LANE_B_INIT;
    hp_words  = 0;
    hp_closed = 1'b0;
  endfunction

  function void hash_round(input logic [31:0] w);
    logic [31:0] b, a, c, m, lo, hi, sum;
    logic [63:0] prod;
    logic [32:0] t;
    hp_rotor = {hp_rotor[30:0], hp_rotor[31]};
    b = hp_rotor ^ rnh_pkg::SALT;
    a = hp_lane_a ^ w;
    c = hp_lane_b ^ w;

    m = ((b + c) | rnh_pkg::SET_A) & rnh_pkg::KEEP_A;
    prod = {32'd0, a} * {32'd0, m};
    lo = prod[31:0];
    hi = prod[63:32];
    t = {1'b0, lo} + {1'b0, hi} + {32'd0, (hi != 32'd0)};
    sum = t[31:0] + {31'd0, t[32]};
    hp_lane_a = sum;

    // Lane B uses a, which holds the pre-round lane A value mixed with the word.
    m = ((b + a) | rnh_pkg::SET_B) & rnh_pkg::KEEP_B;
    prod = {32'd0, c} * {32'd0, m};
    lo = prod[31:0];
    hi = prod[63:32];
    t = {1'b0, lo} + {1'b0, hi[30:0], 1'b0} + {32'd0, hi[31]};
    sum = t[31:0];
    if (t[32]) sum = sum + 32'd2;
    hp_lane_b = sum;
  endfunction

  function void predict_request(input logic kind, input logic [31:0] word);
    if (kind == rnh_pkg::KIND_WORD) begin
      if (!hp_closed && hp_words < rnh_pkg::MAX_WORDS) begin
        if (word == 32'd0) begin
          hp_closed = 1'b1;
        end else begin
          hash_round(word);
          hp_words++;
        end
      end
    end else begin
      hash_round(rnh_pkg::TAIL_WORD0);
      hash_round(rnh_pkg::TAIL_WORD1);
      hash_q.push_back(hp_lane_a ^ hp_lane_b);
      hash_state_reset();
    end
  endfunction

  // Mostly short gaps, a few long ones, none at all while calm.
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] name_word();
    logic [31:0] w;
    w = $urandom;
    if ($urandom_range(0, 3) == 0) begin
      for (int i = 0; i < 4; i++) begin
        if ($urandom_range(0, 1) == 1) w[8*i +: 8] = 8'h00;
      end
    end
    if (w == 32'd0) w = 32'd1 << $urandom_range(0, 31);
    return w;
  endfunction

  task automatic send_req(input logic kind, input logic [31:0] word);
    int gap;
    if ($urandom_range(0, 49) == 0) src_calm = !src_calm;
    gap = pick_gap(src_calm);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.kind  <= kind;
    req_if.word  <= word;
    do @(posedge clk); while (!req_if.ready);
  endtask

  // Result side back-pressure.
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      res_if.ready <= 1'b0;
      sink_hold--;
    end else begin
      res_if.ready <= 1'b1;
      if ($urandom_range(0, 49) == 0) sink_calm = !sink_calm;
      sink_hold = pick_gap(sink_calm);
    end
  end

  // Result checking and request prediction, both on sampled handshakes.
  always @(posedge clk) begin : monitor
    logic [31:0] want;
    if (rst_n) begin
      if (res_if.valid && res_if.ready) begin
        if (hash_q.size() == 0) begin
          report_mismatch("hash with no end request pending", 32'd0, res_if.hash);
        end else begin
          want = hash_q.pop_front();
          if (res_if.hash !== want) report_mismatch("hash", want, res_if.hash);
        end
      end
      if (req_if.valid && req_if.ready) predict_request(req_if.kind, req_if.word);
    end
  end

  initial begin : stimulus
    int taken;
    int len;
    int extra;
    int style;
    taken = DIR_ROWS;
    hash_state_reset();
    rst_n        <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.kind  <= rnh_pkg::KIND_WORD;
    req_if.word  <= 32'd0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) send_req(DIR_TAB[i].kind, DIR_TAB[i].word);

    while (taken < 400) begin
      style = $urandom_range(0, 99);
      if (style < 70) begin
        // Ordinary short name.
        len = $urandom_range(0, 8);
        repeat (len) send_req(rnh_pkg::KIND_WORD, name_word());
        send_req(rnh_pkg::KIND_END, $urandom);
        taken += len + 1;
      end else if (style < 76) begin
        // Long name that can run into the word limit.
        len = $urandom_range(rnh_pkg::MAX_WORDS - 4, rnh_pkg::MAX_WORDS + 6);
        repeat (len) send_req(rnh_pkg::KIND_WORD, name_word());
        send_req(rnh_pkg::KIND_END, $urandom);
        taken += len + 1;
      end else if (style < 90) begin
        // Name closed early by a zero word, followed by words that are dropped.
        len = $urandom_range(0, 5);
        extra = $urandom_range(0, 4);
        repeat (len) send_req(rnh_pkg::KIND_WORD, name_word());
        send_req(rnh_pkg::KIND_WORD, 32'd0);
        repeat (extra) begin
          send_req(rnh_pkg::KIND_WORD, ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom);
        end
        send_req(rnh_pkg::KIND_END, $urandom);
        taken += len + extra + 2;
      end else begin
        // Unstructured requests.
        len = $urandom_range(1, 6);
        repeat (len) send_req(1'($urandom_range(0, 1)), $urandom);
        taken += len;
      end
    end
    req_if.valid <= 1'b0;

    // Let the monitor see the last request before the queue is checked.
    @(posedge clk);
    while (hash_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
